@@ design/dd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_pkg: shared constants for the differential-drive wheel rpm block
// Register indexes, reset values and field widths used by several files.
// ----------------------------------------------------------------------------
package dd_pkg;

    // Default number of fraction bits of the internal rpm values.
    localparam int FRAC_BITS_DEF = 16;

    // Field and register widths.
    localparam int IN_W   = 16;
    localparam int OUT_W  = 15;
    localparam int MAX_W  = 14;
    localparam int GAIN_W = 20;
    localparam int HT_W   = 16;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 20;

    // Register indexes on the configuration port.
    localparam logic [CFG_AW-1:0] REG_MAX_RPM       = 2'd0;
    localparam logic [CFG_AW-1:0] REG_RPM_PER_SPEED = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HALF_TRACK    = 2'd2;

    // Register reset values.
    localparam logic [MAX_W-1:0]  MAX_RPM_RST       = 14'd100;
    localparam logic [GAIN_W-1:0] RPM_PER_SPEED_RST = 20'd24446;
    localparam logic [HT_W-1:0]   HALF_TRACK_RST    = 16'd410;

endpackage

@@ design/dd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_div: pipelined restoring divider
// One quotient bit per stage; the low dividend bits shift out of the top of
// the lo word while quotient bits shift in at its bottom.
// ----------------------------------------------------------------------------
module dd_div #(
    parameter int DW = 41,
    parameter int QW = 30
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] w_rem [QW];
    logic [QW-1:0] w_lo  [QW];
    logic [DW-1:0] w_den [QW];
    logic [QW-1:0] r_lo  [QW];

    assign w_rem[0] = i_rem;
    assign w_lo[0]  = i_lo;
    assign w_den[0] = i_den;
    assign o_quo    = r_lo[QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   n_trial;
        logic          n_ge;

        // Shift in the next dividend bit and try to subtract the divisor.
        always_comb begin
            n_trial = {w_rem[k], w_lo[k][QW-1]};
            n_ge    = (n_trial >= {1'b0, w_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[k] <= {w_lo[k][QW-2:0], n_ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            logic [DW-1:0] n_rem;
            logic [DW-1:0] r_rem;
            logic [DW-1:0] r_den;

            assign n_rem = n_ge ? DW'(n_trial - {1'b0, w_den[k]}) : DW'(n_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_den <= w_den[k];
                end
            end

            assign w_rem[k+1] = r_rem;
            assign w_lo[k+1]  = r_lo[k];
            assign w_den[k+1] = r_den;
        end
    end

endmodule

@@ design/diff_drive_wheel_rpm.sv @@
`timescale 1ns / 1ps
// The result passes through the input stages, the one-bit-per-stage scaling
// divider and the output stage.
// Throughput: one transaction per cycle; the whole pipeline holds on a stall.
// Reset: synchronous active-low; clears all valid bits and loads the register
// reset values (max 100 rpm, gain 24446, half track 410).
// ----------------------------------------------------------------------------
// diff_drive_wheel_rpm: differential-drive inverse kinematics
// Turns forward speed and turn rate into clamped left and right wheel rpm.
// ----------------------------------------------------------------------------
module diff_drive_wheel_rpm #(
    parameter int FRAC_BITS = dd_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dd_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [dd_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [15:0] linear_speed, [31:16] turn_rate
    input  logic [31:0]               s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [14:0] left_rpm, [29:15] right_rpm, [31:30] zero
    output logic [31:0]               m_axis_tdata
);

    localparam int UP   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int DN   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int TDN  = 28 - FRAC_BITS;
    localparam int AXW  = 36 + UP;
    localparam int ATW  = 52 - TDN;
    localparam int MW   = (AXW > ATW) ? AXW : ATW;
    localparam int SUMW = MW + 1;
    localparam int QW   = dd_pkg::MAX_W + FRAC_BITS;
    localparam int PW   = MW + dd_pkg::MAX_W;
    localparam int SCW  = 5 + 2 * MW;
    localparam int VW   = MW + 2;
    localparam int NST  = 7 + QW;
    localparam int OUT_W = dd_pkg::OUT_W;

    // Configuration registers.
    logic [dd_pkg::MAX_W-1:0]  r_max;
    logic [dd_pkg::GAIN_W-1:0] r_gain;
    logic [dd_pkg::HT_W-1:0]   r_ht;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= dd_pkg::MAX_RPM_RST;
            r_gain <= dd_pkg::RPM_PER_SPEED_RST;
            r_ht   <= dd_pkg::HALF_TRACK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dd_pkg::REG_MAX_RPM:       r_max  <= i_cfg_data[dd_pkg::MAX_W-1:0];
                dd_pkg::REG_RPM_PER_SPEED: r_gain <= i_cfg_data;
                dd_pkg::REG_HALF_TRACK:    r_ht   <= i_cfg_data[dd_pkg::HT_W-1:0];
                default: ;
            endcase
        end
    end

    // Global pipeline enable: advance unless a result waits at the output and is not taken.
    logic           w_en;
    logic [NST-1:0] r_vld;

    assign w_en          = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: sign and magnitude of the inputs.
    logic [15:0] w_s, w_w;
    logic [15:0] r_sm, r_wm;
    logic        r_sneg1, r_wneg1, r_wz1;

    assign w_s = s_axis_tdata[15:0];
    assign w_w = s_axis_tdata[31:16];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sneg1 <= w_s[15];
            r_wneg1 <= w_w[15];
            r_wz1   <= (w_w == '0);
            r_sm    <= w_s[15] ? 16'(-w_s) : w_s;
            r_wm    <= w_w[15] ? 16'(-w_w) : w_w;
        end
    end

    // Stage 2: forward product and turn rate times half track.
    logic [35:0] r_px;
    logic [31:0] r_pt;
    logic        r_sneg2, r_wneg2, r_wz2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px    <= 36'(r_sm) * 36'(r_gain);
            r_pt    <= 32'(r_wm) * 32'(r_ht);
            r_sneg2 <= r_sneg1;
            r_wneg2 <= r_wneg1;
            r_wz2   <= r_wz1;
        end
    end

    // Stage 3: forward and turn rpm magnitudes in the internal format.
    logic [51:0]   w_pt3;
    logic [MW-1:0] r_ax, r_at;
    logic          r_sneg3, r_wneg3, r_wz3;

    assign w_pt3 = 52'(r_pt) * 52'(r_gain);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax    <= MW'(MW'(r_px) << UP) >> DN;
            r_at    <= MW'(w_pt3 >> TDN);
            r_sneg3 <= r_sneg2;
            r_wneg3 <= r_wneg2;
            r_wz3   <= r_wz2;
        end
    end

    // Stage 4: sum of magnitudes and choice of saturation rule.
    logic [MW-1:0]   w_m;
    logic [SUMW-1:0] w_sum;
    logic [SUMW-1:0] r_sum;
    logic [SCW-1:0]  r_sc4;

    assign w_m   = MW'(r_max) << FRAC_BITS;
    assign w_sum = SUMW'(r_ax) + SUMW'(r_at);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= w_sum;
            // {sneg, wneg, straight, scale, zero_sum, ax, at}
            r_sc4 <= {r_sneg3, r_wneg3,
                      (r_wz3 && r_ax >= w_m),
                      !(r_wz3 && r_ax >= w_m) && (w_sum >= SUMW'(w_m)),
                      (w_sum == '0), r_ax, r_at};
        end
    end

    // Stage 5: numerators of the scaling, split for the divider.
    logic [PW-1:0]   w_pa, w_pb;
    logic [SUMW-1:0] r_rem_a, r_rem_b, r_den;
    logic [QW-1:0]   r_lo_a, r_lo_b;
    logic [SCW-1:0]  r_sc [QW+1];

    assign w_pa = PW'(r_sc4[2*MW-1:MW]) * PW'(r_max);
    assign w_pb = PW'(r_sc4[MW-1:0]) * PW'(r_max);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem_a <= SUMW'(w_pa >> dd_pkg::MAX_W);
            r_rem_b <= SUMW'(w_pb >> dd_pkg::MAX_W);
            r_lo_a  <= {w_pa[dd_pkg::MAX_W-1:0], {FRAC_BITS{1'b0}}};
            r_lo_b  <= {w_pb[dd_pkg::MAX_W-1:0], {FRAC_BITS{1'b0}}};
            r_den   <= r_sum;
            r_sc[0] <= r_sc4;
        end
    end

    // Side data travels beside the divider stages.
    for (genvar k = 1; k <= QW; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sc[k] <= r_sc[k-1];
            end
        end
    end

    logic [QW-1:0] w_qa, w_qb;

    dd_div #(.DW(SUMW), .QW(QW)) u_div_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r_rem_a),
        .i_lo  (r_lo_a),
        .i_den (r_den),
        .o_quo (w_qa)
    );

    dd_div #(.DW(SUMW), .QW(QW)) u_div_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r_rem_b),
        .i_lo  (r_lo_b),
        .i_den (r_den),
        .o_quo (w_qb)
    );

    // Stage C: pick the final magnitudes and form left and right.
    logic [SCW-1:0]       w_sc;
    logic [MW-1:0]        w_axf, w_atf;
    logic signed [VW-1:0] w_x, w_t;
    logic signed [VW-1:0] r_l, r_r;

    assign w_sc = r_sc[QW];

    always_comb begin
        w_axf = w_sc[2*MW-1:MW];
        w_atf = w_sc[MW-1:0];
        if (w_sc[2*MW+2]) begin
            w_axf = w_m;
        end else if (w_sc[2*MW+1]) begin
            w_axf = w_sc[2*MW] ? '0 : MW'(w_qa);
            w_atf = w_sc[2*MW] ? '0 : MW'(w_qb);
        end
        w_x = w_sc[2*MW+4] ? -$signed(VW'(w_axf)) : $signed(VW'(w_axf));
        w_t = w_sc[2*MW+3] ? -$signed(VW'(w_atf)) : $signed(VW'(w_atf));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l <= w_x - w_t;
            r_r <= w_x + w_t;
        end
    end

    // Output stage: truncate toward zero, clamp and register the result.
    function automatic logic [OUT_W-1:0] wheel(input logic signed [VW-1:0] v,
                                               input logic [dd_pkg::MAX_W-1:0] mx);
        logic [VW-1:0]             mag;
        logic [VW-FRAC_BITS-1:0]   ip;
        logic [OUT_W-1:0]          lim;
        mag = v[VW-1] ? VW'(-v) : VW'(v);
        ip  = mag[VW-1:FRAC_BITS];
        lim = (ip > (VW-FRAC_BITS)'(mx)) ? OUT_W'(mx) : OUT_W'(ip);
        return v[VW-1] ? OUT_W'(-lim) : lim;
    endfunction

    logic [OUT_W-1:0] r_lo_rpm, r_ro_rpm;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lo_rpm <= wheel(r_l, r_max);
            r_ro_rpm <= wheel(r_r, r_max);
        end
    end

    assign m_axis_tdata = {2'b00, r_ro_rpm, r_lo_rpm};

endmodule

@@ design/dd_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_chk: port-level checks for the wheel rpm block
// Watches the stream ports and confirms stall, reset and range behavior.
// ----------------------------------------------------------------------------
module dd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result keeps its transaction data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The input side is open whenever no result waits.
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Clamped rpm never reaches the most negative code; pad bits are zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:0] != 15'h4000 &&
                          m_axis_tdata[29:15] != 15'h4000 &&
                          m_axis_tdata[31:30] == 2'b00)
        else $error("result out of range");

endmodule

bind diff_drive_wheel_rpm dd_chk u_dd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/diff_drive_wheel_rpm_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_wheel_rpm_test: self-checking bench for the wheel rpm block
// Drives speed and turn commands with random gaps, computes the expected
// wheel rpm for each accepted transaction and compares results in order.
// ----------------------------------------------------------------------------
module diff_drive_wheel_rpm_test;
    import dd_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 21 + FB;

    typedef struct packed {
        logic signed [OUT_W-1:0] right_rpm;
        logic signed [OUT_W-1:0] left_rpm;
    } wheel_pair_t;

    // Scoreboard with its own copy of the registers.
    class wheel_scoreboard;
        logic [MAX_W-1:0]  max_rpm;
        logic [GAIN_W-1:0] gain;
        logic [HT_W-1:0]   half_track;
        wheel_pair_t       pending[$];
        int                errors;

        function void reset_regs();
            max_rpm = MAX_RPM_RST;
            gain = RPM_PER_SPEED_RST;
            half_track = HALF_TRACK_RST;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            if (idx == REG_MAX_RPM) max_rpm = val[MAX_W-1:0];
            else if (idx == REG_RPM_PER_SPEED) gain = val[GAIN_W-1:0];
            else if (idx == REG_HALF_TRACK) half_track = val[HT_W-1:0];
        endfunction

        // Long division giving floor(mag * max * 2^FB / sum).
        function logic [127:0] scale(logic [127:0] mag, logic [127:0] sum);
            logic [127:0] p, q, r;
            p = mag * max_rpm;
            q = p / sum;
            r = p % sum;
            for (int i = 0; i < FB; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= sum) begin
                    r = r - sum;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        // Truncate toward zero to whole rpm and clamp to max.
        function logic [OUT_W-1:0] wheel(logic signed [127:0] v);
            logic [127:0] m;
            m = (v < 0) ? -v : v;
            m = m >> FB;
            if (m > max_rpm) m = max_rpm;
            return (v < 0) ? -m[OUT_W-1:0] : m[OUT_W-1:0];
        endfunction

        function void note_command(logic [31:0] d);
            logic signed [15:0]  s, w;
            logic [127:0]        sm, wm, ax, at, sum, lim;
            logic signed [127:0] x, t;
            wheel_pair_t         e;
            s = d[15:0];
            w = d[31:16];
            sm = (s < 0) ? -128'(s) : 128'(s);
            wm = (w < 0) ? -128'(w) : 128'(w);
            lim = 128'(max_rpm) << FB;
            ax = sm * gain;
            if (FB >= 16) ax = ax << (FB - 16);
            else ax = ax >> (16 - FB);
            at = (wm * half_track * gain) >> (28 - FB);
            sum = ax + at;
            if (w == 0 && ax >= lim) begin
                ax = lim;
            end else if (sum >= lim) begin
                if (sum == 0) begin
                    ax = 0;
                    at = 0;
                end else begin
                    ax = scale(ax, sum);
                    at = scale(at, sum);
                end
            end
            x = (s < 0) ? -ax : ax;
            t = (w < 0) ? -at : at;
            e.left_rpm = wheel(x - t);
            e.right_rpm = wheel(x + t);
            pending.push_back(e);
        endfunction

        function void check_result(logic [31:0] d);
            wheel_pair_t got, e;
            got = d[29:0];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (got.left_rpm !== e.left_rpm || got.right_rpm !== e.right_rpm
                || d[31:30] !== 2'b00) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: left exp %0d got %0d, right exp %0d got %0d",
                             e.left_rpm, got.left_rpm, e.right_rpm, got.right_rpm);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    wheel_scoreboard sb = new();

    diff_drive_wheel_rpm dut (.*);

    always #1 i_clk = ~i_clk;

    // Sample accepted results at the rising edge.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    // Receiver with random stalls, sometimes none for a stretch.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
                if (gap > 0) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    task automatic send_command(logic [15:0] speed, logic [15:0] turn);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {turn, speed};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command({turn, speed});
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Let the pipeline empty before touching the registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [15:0] s, w;
        for (int i = 0; i < n; i++) begin
            s = 16'($urandom);
            w = 16'($urandom);
            case ($urandom_range(0, 5))
                0: w = 16'h0000;
                1: s = 16'($urandom_range(0, 512) - 256);
                2: w = 16'($urandom_range(0, 512) - 256);
                default: ;
            endcase
            send_command(s, w);
        end
    endtask

    initial begin
        logic [15:0] edge_vals[6];
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
        sb.reset_regs();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners at reset values.
        foreach (edge_vals[a])
            for (int b = 0; b < 4; b++) send_command(edge_vals[a], edge_vals[b]);
        random_phase(150);
        drain();

        // Largest settings.
        write_reg(REG_MAX_RPM, 20'h03FFF);
        write_reg(REG_RPM_PER_SPEED, 20'hFFFFF);
        write_reg(REG_HALF_TRACK, 20'h0FFFF);
        send_command(16'h8000, 16'h8000);
        send_command(16'h7FFF, 16'h0000);
        random_phase(150);
        drain();

        // Smallest nonzero max, zero half track, unused index.
        write_reg(REG_MAX_RPM, 20'd1);
        write_reg(REG_HALF_TRACK, 20'd0);
        write_reg(2'd3, CFG_DW'($urandom));
        send_command(16'h0000, 16'h0000);
        send_command(16'h0100, 16'h0100);
        random_phase(120);
        drain();

        // Zero gain and zero max.
        write_reg(REG_RPM_PER_SPEED, 20'd0);
        write_reg(REG_MAX_RPM, 20'd0);
        random_phase(60);
        drain();

        // Random registers for the rest.
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_MAX_RPM, CFG_DW'($urandom_range(1, 16383)));
            write_reg(REG_RPM_PER_SPEED, CFG_DW'($urandom_range(0, 20'hFFFFF)));
            write_reg(REG_HALF_TRACK, CFG_DW'($urandom_range(0, 16'hFFFF)));
            random_phase(60);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/dd_pkg.sv
design/dd_div.sv
design/diff_drive_wheel_rpm.sv
design/dd_chk.sv
dv/diff_drive_wheel_rpm_test.sv
